// ===== sv/rsab_pkg.sv =====
// Package with shared constants, types and functions of the RGB sample accumulation buffer.
package rsab_pkg;

	localparam int DEF_IMAGE_WIDTH  = 256;
	localparam int DEF_IMAGE_HEIGHT = 256;

	localparam int ACC_W  = 32;
	localparam int SMP_W  = 24;
	localparam int CFG_W  = 16;
	localparam int LG_W   = 21;

	localparam logic [15:0] SAMPLE_COUNT_RST  = 16'd1;
	localparam logic [15:0] INVERSE_GAMMA_RST = 16'd1862;

	typedef enum logic [1:0] {
		MODE_ACCUM = 2'd0,
		MODE_WRITE = 2'd1,
		MODE_READ  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic {
		REG_SAMPLE_COUNT  = 1'b0,
		REG_INVERSE_GAMMA = 1'b1
	} reg_idx_t;

	// Control passed from the top level to the resolve unit.
	typedef struct packed {
		logic        start;
		logic        addr_ok;
		logic [15:0] sample_count;
		logic [15:0] inverse_gamma;
	} rsv_ctrl_t;

	// Q16 base-2 logarithm lg(b) of the byte values 1..255; b = 0 gives 0.
	function automatic logic [LG_W-1:0] lg_const(input logic [7:0] b);
		logic [LG_W-1:0] top;
		logic [33:0]     m;
		logic [15:0]     frac;
		logic [7:0]      t;
		top  = '0;
		frac = '0;
		t    = b;
		for (int i = 0; i < 8; i++) begin
			if (t > 8'd1) begin
				t   = t >> 1;
				top = top + 1'b1;
			end
		end
		m = {18'd0, b, 8'd0} << (16 - 8);
		m = 34'(b) << (16 - top);
		for (int i = 0; i < 16; i++) begin
			m = 34'((m * m) >> 16);
			if (m >= 34'(1 << 17)) begin
				m = m >> 1;
				frac[15-i] = 1'b1;
			end
		end
		return LG_W'({top[4:0], frac});
	endfunction

endpackage

// ===== sv/rsab_resolve.sv =====
// Iterative readout unit: divide, logarithm, exponent scale and byte search for three channels.
module rsab_resolve (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rsab_pkg::rsv_ctrl_t   ctrl,
	input  logic [95:0]           pixel,
	output logic                  done,
	output logic [7:0]            red_byte,
	output logic [7:0]            green_byte,
	output logic [7:0]            blue_byte
);
	import rsab_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_DIV, S_LOGN, S_LOG, S_MUL, S_SRCH, S_DONE
	} state_t;

	state_t          state_q;
	logic [1:0]      ch_q;
	logic [5:0]      cnt_q;
	logic [31:0]     rem_q;
	logic [31:0]     quo_q;
	logic [16:0]     m_q;
	logic [15:0]     frac_q;
	logic [4:0]      top_q;
	logic [36:0]     p_q;
	logic [7:0]      b_q;
	logic [95:0]     pix_q;
	logic [15:0]     div_q;
	logic [15:0]     gam_q;
	logic            ok_q;
	logic [7:0]      res_q [3];

	logic [32:0] rem_sh;
	logic [33:0] msq;
	logic [4:0]  top_c;
	logic [LG_W-1:0] lgq;
	logic [LG_W-1:0] l255;
	logic [LG_W-1:0] lg_tab [256];

	assign rem_sh = {rem_q, quo_q[31]};
	assign msq    = 34'({17'd0, m_q} * {17'd0, m_q}) >> 16;
	assign lgq    = {top_q, frac_q};
	assign l255   = lg_const(8'd255);

	// Constant table of the byte logarithms used by the search.
	always_comb begin
		for (int i = 0; i < 256; i++)
			lg_tab[i] = lg_const(8'(i));
	end

	always_comb begin
		top_c = '0;
		for (int i = 0; i < 16; i++)
			if (quo_q[i]) top_c = 5'(i);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (ctrl.start) begin
						pix_q   <= pixel;
						div_q   <= (ctrl.sample_count == 16'd0) ? 16'd1 : ctrl.sample_count;
						gam_q   <= ctrl.inverse_gamma;
						ok_q    <= ctrl.addr_ok;
						ch_q    <= 2'd0;
						state_q <= S_DIV;
						cnt_q   <= '0;
						rem_q   <= '0;
						quo_q   <= pixel[31:0];
					end
				end
				S_DIV: begin
					if (rem_sh >= {17'd0, div_q}) begin
						rem_q <= 32'(rem_sh - {17'd0, div_q});
						quo_q <= {quo_q[30:0], 1'b1};
					end else begin
						rem_q <= rem_sh[31:0];
						quo_q <= {quo_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd31) state_q <= S_LOGN;
				end
				S_LOGN: begin
					if (!ok_q) begin
						res_q[ch_q] <= 8'd0;
						state_q <= S_DONE;
					end else if (gam_q == 16'd0 || quo_q >= 32'd65536) begin
						res_q[ch_q] <= 8'd255;
						state_q <= S_DONE;
					end else if (quo_q == 32'd0) begin
						res_q[ch_q] <= 8'd0;
						state_q <= S_DONE;
					end else begin
						top_q   <= top_c;
						m_q     <= 17'(quo_q << (16 - top_c));
						frac_q  <= '0;
						cnt_q   <= '0;
						state_q <= S_LOG;
					end
				end
				S_LOG: begin
					if (msq >= 34'h20000) begin
						m_q <= msq[17:1];
						frac_q[4'(15 - cnt_q[3:0])] <= 1'b1;
					end else begin
						m_q <= msq[16:0];
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 6'd15) state_q <= S_MUL;
				end
				S_MUL: begin
					p_q     <= 37'(({16'd0, LG_W'(21'h100000 - lgq)} * {21'd0, gam_q}) >> 12);
					b_q     <= 8'd255;
					state_q <= S_SRCH;
				end
				S_SRCH: begin
					if ({16'd0, LG_W'(l255 - lg_tab[b_q])} >= p_q) begin
						res_q[ch_q] <= b_q;
						state_q <= S_DONE;
					end else if (b_q == 8'd1) begin
						res_q[ch_q] <= 8'd0;
						state_q <= S_DONE;
					end else begin
						b_q <= b_q - 1'b1;
					end
				end
				S_DONE: begin
					if (ch_q == 2'd2) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						ch_q    <= ch_q + 1'b1;
						cnt_q   <= '0;
						rem_q   <= '0;
						quo_q   <= pix_q[(ch_q+1)*32 +: 32];
						state_q <= S_DIV;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign red_byte   = res_q[0];
	assign green_byte = res_q[1];
	assign blue_byte  = res_q[2];
endmodule

// ===== sv/rgb_sample_accumulation_buffer.sv =====
// Top level of the RGB sample accumulation buffer: pixel store, update path and readout control.
// Accumulate and overwrite pass through read, modify and write back; one item at a time.
// A read runs from acceptance to out_valid through, per channel, a 32-step divider,
// then, unless a special case settles it, a 16-step logarithm and a byte search of 1 to 255 steps.
// Reset resets control state and starts a clearing pass over the pixel store, one entry
// per cycle, covering all IMAGE_WIDTH*IMAGE_HEIGHT entries; no transaction is accepted meanwhile.
module rgb_sample_accumulation_buffer #(
	parameter int IMAGE_WIDTH  = rsab_pkg::DEF_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = rsab_pkg::DEF_IMAGE_HEIGHT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  row,
	input  logic [7:0]  column,
	input  logic [23:0] red_sample,
	input  logic [23:0] green_sample,
	input  logic [23:0] blue_sample,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  red_byte,
	output logic [7:0]  green_byte,
	output logic [7:0]  blue_byte,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import rsab_pkg::*;

	localparam int PIXELS = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW     = (PIXELS > 1) ? $clog2(PIXELS) : 1;

	typedef enum logic [2:0] {
		T_CLEAR, T_IDLE, T_RD, T_WB, T_RES, T_OUT
	} state_t;

	// The pixel store: three 32-bit Q16.16 channels per entry, read through the rd_q register.
	logic [95:0] store [PIXELS];
	logic [95:0] rd_q;

	state_t      state_q;
	logic [AW:0] clr_q;
	logic [AW-1:0] addr_q;
	logic        ok_q;
	logic [1:0]  mode_q;
	logic [71:0] smp_q;
	logic [15:0] sample_count_q;
	logic [15:0] inverse_gamma_q;
	logic        we;
	logic [AW-1:0] waddr;
	logic [95:0] wdata;
	logic [95:0] upd;
	logic        in_ok;
	logic [31:0] lin;

	rsv_ctrl_t   rctl;
	logic        rdone;
	logic [7:0]  r_b, g_b, b_b;

	assign in_stall = (state_q != T_IDLE);
	assign lin   = 32'(row) * 32'(IMAGE_WIDTH) + 32'(column);
	assign in_ok = (32'(row) < 32'(IMAGE_HEIGHT)) && (32'(column) < 32'(IMAGE_WIDTH));

	// Saturating add of each sample onto its channel.
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			logic [32:0] s;
			s = {1'b0, rd_q[c*32 +: 32]} + {9'd0, smp_q[c*24 +: 24]};
			upd[c*32 +: 32] = s[32] ? 32'hFFFF_FFFF : s[31:0];
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = upd;
		if (state_q == T_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q[AW-1:0];
			wdata = '0;
		end else if (state_q == T_WB && ok_q) begin
			we = 1'b1;
			if (mode_t'(mode_q) == MODE_WRITE)
				wdata = {8'd0, smp_q[71:48], 8'd0, smp_q[47:24], 8'd0, smp_q[23:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (we) store[waddr] <= wdata;
		rd_q <= store[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= T_CLEAR;
			clr_q           <= '0;
			out_valid       <= 1'b0;
			sample_count_q  <= SAMPLE_COUNT_RST;
			inverse_gamma_q <= INVERSE_GAMMA_RST;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_SAMPLE_COUNT:  sample_count_q  <= cfg_data;
					REG_INVERSE_GAMMA: inverse_gamma_q <= cfg_data;
					default: ;
				endcase
			end
			case (state_q)
				T_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == (AW+1)'(PIXELS - 1)) state_q <= T_IDLE;
				end
				T_IDLE: begin
					if (in_valid) begin
						addr_q <= in_ok ? lin[AW-1:0] : '0;
						ok_q   <= in_ok;
						mode_q <= mode;
						smp_q  <= {blue_sample, green_sample, red_sample};
						state_q <= (mode_t'(mode) == MODE_NONE) ? T_IDLE : T_RD;
					end
				end
				T_RD: begin
					// The read data of the addressed entry lands in rd_q this cycle.
					state_q <= (mode_t'(mode_q) == MODE_READ) ? T_RES : T_WB;
				end
				T_WB: state_q <= T_IDLE;
				T_RES: begin
					if (rdone) begin
						red_byte   <= r_b;
						green_byte <= g_b;
						blue_byte  <= b_b;
						out_valid  <= 1'b1;
						state_q    <= T_OUT;
					end
				end
				T_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	always_comb begin
		rctl.start         = (state_q == T_RD) && (mode_t'(mode_q) == MODE_READ);
		rctl.addr_ok       = ok_q;
		rctl.sample_count  = sample_count_q;
		rctl.inverse_gamma = inverse_gamma_q;
	end

	// Start is registered in rctl_s1, so the resolve unit sees it on T_RES entry and samples rd_q then.
	rsv_ctrl_t rctl_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rctl_s1 <= '0;
		else         rctl_s1 <= rctl;
	end

	rsab_resolve u_resolve (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (rctl_s1),
		.pixel     (rd_q),
		.done      (rdone),
		.red_byte  (r_b),
		.green_byte(g_b),
		.blue_byte (b_b)
	);
endmodule
